[rtl/gb7_pkg.sv]
// shared types, kernel weights and register codes for the 7x7 blur
`timescale 1ns / 1ps
package gb7_pkg;

   localparam int PIX_W    = 24;
   localparam int CH_W     = 8;
   localparam int TAPS     = 7;
   localparam int COLSUM_W = 12;
   localparam int TOTAL_W  = 15;

   // register indexes on the csr port
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 13;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;
   localparam int IMG_W_REG_W = 11;
   localparam int IMG_H_REG_W = 13;

   // sum / 84 as (sum * 49933) >> 22, exact for sums up to 255 * 84
   localparam int DIV_MULT_W = 16;
   localparam logic [DIV_MULT_W-1:0] DIV_MULT = 16'd49933;
   localparam int DIV_SHIFT  = 22;
   localparam int PROD_W     = TOTAL_W + DIV_MULT_W;

   localparam logic [2:0] KERNEL [0:TAPS-1][0:TAPS-1] = '{
      '{3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1},
      '{3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1},
      '{3'd1, 3'd2, 3'd3, 3'd3, 3'd3, 3'd2, 3'd1},
      '{3'd1, 3'd2, 3'd3, 3'd4, 3'd3, 3'd2, 3'd1},
      '{3'd1, 3'd2, 3'd3, 3'd3, 3'd3, 3'd2, 3'd1},
      '{3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1},
      '{3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1}
   };

   // one vertical column of the window, entry 0 is the oldest row
   typedef logic [TAPS-1:0][PIX_W-1:0] pix_col_type;

   typedef struct packed {
      logic [COLSUM_W-1:0] red;
      logic [COLSUM_W-1:0] green;
      logic [COLSUM_W-1:0] blue;
   } col_sum_type;

   typedef struct packed {
      logic shift;
      logic fill;
   } cell_ctl_type;

endpackage

[rtl/gb7_ram.sv]
// simple dual port ram with registered read
`timescale 1ns / 1ps
module gb7_ram #(
   parameter int WIDTH = 144,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/gb7_cell.sv]
// one window column cell: holds seven pixels and forms its weighted column sums
`timescale 1ns / 1ps
module gb7_cell #(
   parameter int COL = 0
) (
   input  logic                 clock,
   input  gb7_pkg::cell_ctl_type ctl,
   input  gb7_pkg::pix_col_type shift_in,
   input  gb7_pkg::pix_col_type fill_in,
   output gb7_pkg::pix_col_type col_out,
   output gb7_pkg::col_sum_type sum_out
);
   import gb7_pkg::*;

   pix_col_type col_ff;
   pix_col_type col_in;

   always_comb begin
      col_in = col_ff;
      if (ctl.shift) begin
         col_in = ctl.fill ? fill_in : shift_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
   end

   always_comb begin
      sum_out = '0;
      for (int k = 0; k < TAPS; k++) begin
         sum_out.red   = sum_out.red
                       + COLSUM_W'(col_ff[k][23:16]) * COLSUM_W'(KERNEL[k][COL]);
         sum_out.green = sum_out.green
                       + COLSUM_W'(col_ff[k][15:8]) * COLSUM_W'(KERNEL[k][COL]);
         sum_out.blue  = sum_out.blue
                       + COLSUM_W'(col_ff[k][7:0]) * COLSUM_W'(KERNEL[k][COL]);
      end
   end

   assign col_out = col_ff;
endmodule

[rtl/gaussian_blur_7x7_clamp_edge.sv]
// top level of the streaming 7x7 gaussian blur with replicated edges
// a result is registered in stage 1, then in the window cells with e1, e2, e3 and the output register
// throughput: one item per cycle while the output takes data; an item ending a row from input
//   row 3 on holds the input while the window replays its right edge column
// reset clears counters and pipeline valids and sets the csr registers to width and height 1024
// the line store needs no clearing; its rows are written before they are read
`timescale 1ns / 1ps
module gaussian_blur_7x7_clamp_edge #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   // pixel input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic [7:0]                        req_red_in,
   input  logic [7:0]                        req_green_in,
   input  logic [7:0]                        req_blue_in,
   // blurred output
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_red_out,
   output logic [7:0]                        rsp_green_out,
   output logic [7:0]                        rsp_blue_out,
   output logic                              rsp_last_of_run,
   output logic                              rsp_last_of_frame,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gb7_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gb7_pkg::CSR_DAT_W-1:0]     csr_wdata
);
   import gb7_pkg::*;

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int WCW  = ($clog2(MAX_WIDTH + 1) > IMG_W_REG_W) ?
                         $clog2(MAX_WIDTH + 1) : IMG_W_REG_W;
   localparam int RW   = $clog2(MAX_HEIGHT + 3);
   localparam int HCW  = ($clog2(MAX_HEIGHT + 3) > IMG_H_REG_W) ?
                         $clog2(MAX_HEIGHT + 3) : IMG_H_REG_W;
   localparam int ST_W = (TAPS - 1) * PIX_W;

   // csr registers
   logic [IMG_W_REG_W-1:0] width_ff;
   logic [IMG_H_REG_W-1:0] height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMG_W_REG_W'(1024);
         height_ff <= IMG_H_REG_W'(1024);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_ff  <= csr_wdata[IMG_W_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective frame size, saturated to the supported range
   logic [WCW-1:0] w_eff;
   logic [HCW-1:0] h_eff;

   always_comb begin
      w_eff = WCW'(width_ff);
      if (w_eff < WCW'(4)) w_eff = WCW'(4);
      if (w_eff > WCW'(MAX_WIDTH)) w_eff = WCW'(MAX_WIDTH);
      h_eff = HCW'(height_ff);
      if (h_eff < HCW'(4)) h_eff = HCW'(4);
      if (h_eff > HCW'(MAX_HEIGHT)) h_eff = HCW'(MAX_HEIGHT);
   end

   // pipeline control: the stages move together when the output can take data, stage 1 only outside an edge replay
   logic       rsp_valid_ff;
   logic       adv;
   logic [1:0] extra_cnt_ff;
   logic       s1_valid_ff;
   logic       s1_move;
   logic       extra_step;
   logic       accept;

   assign adv        = !rsp_valid_ff || !rsp_stall;
   assign s1_move    = s1_valid_ff && adv && (extra_cnt_ff == 2'd0);
   assign extra_step = adv && (extra_cnt_ff != 2'd0);
   assign req_stall  = !(adv && (extra_cnt_ff == 2'd0));
   assign accept     = req_valid && !req_stall;

   // column and row position of the next input
   logic [CW-1:0] c_ff;
   logic [RW-1:0] r_ff;
   logic          row_end;
   logic          frame_end;

   assign row_end   = WCW'(c_ff) >= (w_eff - WCW'(1));
   assign frame_end = row_end && (HCW'(r_ff) >= (h_eff + HCW'(2)));

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff <= '0;
         r_ff <= '0;
      end else if (accept) begin
         if (row_end) begin
            c_ff <= '0;
            r_ff <= frame_end ? '0 : r_ff + RW'(1);
         end else begin
            c_ff <= c_ff + CW'(1);
         end
      end
   end

   // stage 1: line store read data lines up with the item
   logic [PIX_W-1:0] s1_pix_ff;
   logic             s1_mode_ff;
   logic [CW-1:0]    s1_c_ff;
   logic             s1_r_zero_ff;
   logic             s1_r_ge3_ff;
   logic             s1_row_end_ff;
   logic             s1_frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff       <= {req_red_in, req_green_in, req_blue_in};
         s1_mode_ff      <= req_mode;
         s1_c_ff         <= c_ff;
         s1_r_zero_ff    <= (r_ff == '0);
         s1_r_ge3_ff     <= (r_ff >= RW'(3));
         s1_row_end_ff   <= row_end;
         s1_frame_end_ff <= frame_end;
      end
   end

   // line store: six rows of one column per word, oldest row in the low slot
   logic [ST_W-1:0]  st_rd_data;
   logic [ST_W-1:0]  st_wr_data;
   logic [PIX_W-1:0] s1_pix;
   pix_col_type      s1_col;

   gb7_ram #(
      .WIDTH (ST_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_c_ff),
      .wr_data (st_wr_data),
      .rd_en   (accept),
      .rd_addr (c_ff),
      .rd_data (st_rd_data)
   );

   always_comb begin
      // a drain item repeats the pixel above, except on the top row
      s1_pix = s1_pix_ff;
      if (s1_mode_ff && !s1_r_zero_ff) begin
         s1_pix = st_rd_data[5*PIX_W +: PIX_W];
      end
      if (s1_r_zero_ff) begin
         // top edge: every row above takes the first row's pixel
         for (int k = 0; k < TAPS; k++) s1_col[k] = s1_pix;
         for (int k = 0; k < TAPS - 1; k++) st_wr_data[k*PIX_W +: PIX_W] = s1_pix;
      end else begin
         for (int k = 0; k < TAPS - 1; k++) s1_col[k] = st_rd_data[k*PIX_W +: PIX_W];
         s1_col[TAPS-1] = s1_pix;
         for (int k = 0; k < TAPS - 1; k++) st_wr_data[k*PIX_W +: PIX_W] = s1_col[k+1];
      end
   end

   // right edge replay after a row end
   logic frame_pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         extra_cnt_ff <= 2'd0;
      end else if (s1_move && s1_row_end_ff && s1_r_ge3_ff) begin
         extra_cnt_ff <= 2'd3;
      end else if (extra_step) begin
         extra_cnt_ff <= extra_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         frame_pend_ff <= s1_frame_end_ff;
      end
   end

   // chain of window column cells, cell 6 takes the newest column
   pix_col_type  cell_col [TAPS];
   col_sum_type  cell_sum [TAPS];
   pix_col_type  new_col;
   cell_ctl_type cell_ctl;

   assign new_col        = extra_step ? cell_col[TAPS-1] : s1_col;
   assign cell_ctl.shift = s1_move || extra_step;
   // left edge: the first column of a row fills the whole window
   assign cell_ctl.fill  = s1_move && (s1_c_ff == '0);

   for (genvar m = 0; m < TAPS; m++) begin : g_cell
      gb7_cell #(
         .COL (m)
      ) u_cell (
         .clock    (clock),
         .ctl      (cell_ctl),
         .shift_in ((m == TAPS - 1) ? new_col : cell_col[(m + 1) % TAPS]),
         .fill_in  (s1_col),
         .col_out  (cell_col[m]),
         .sum_out  (cell_sum[m])
      );
   end

   // e1: window just shifted holds a result
   logic e1_valid_ff;
   logic e1_run_ff;
   logic e1_frame_ff;
   logic emit;

   assign emit = s1_move ? (s1_r_ge3_ff && (s1_c_ff >= CW'(3))) : extra_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
      end else if (adv) begin
         e1_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e1_run_ff   <= s1_move ? !s1_row_end_ff : (extra_cnt_ff == 2'd1);
         e1_frame_ff <= extra_step && (extra_cnt_ff == 2'd1) && frame_pend_ff;
      end
   end

   // e2: registered column sums
   logic        e2_valid_ff;
   logic        e2_run_ff;
   logic        e2_frame_ff;
   col_sum_type e2_sum_ff [TAPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         e2_valid_ff <= 1'b0;
      end else if (adv) begin
         e2_valid_ff <= e1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e2_run_ff   <= e1_run_ff;
         e2_frame_ff <= e1_frame_ff;
         for (int m = 0; m < TAPS; m++) e2_sum_ff[m] <= cell_sum[m];
      end
   end

   // e3: window totals per channel
   logic               e3_valid_ff;
   logic               e3_run_ff;
   logic               e3_frame_ff;
   logic [TOTAL_W-1:0] e3_red_ff;
   logic [TOTAL_W-1:0] e3_green_ff;
   logic [TOTAL_W-1:0] e3_blue_ff;
   logic [TOTAL_W-1:0] tot_red;
   logic [TOTAL_W-1:0] tot_green;
   logic [TOTAL_W-1:0] tot_blue;

   always_comb begin
      tot_red   = '0;
      tot_green = '0;
      tot_blue  = '0;
      for (int m = 0; m < TAPS; m++) begin
         tot_red   = tot_red   + TOTAL_W'(e2_sum_ff[m].red);
         tot_green = tot_green + TOTAL_W'(e2_sum_ff[m].green);
         tot_blue  = tot_blue  + TOTAL_W'(e2_sum_ff[m].blue);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e3_valid_ff <= 1'b0;
      end else if (adv) begin
         e3_valid_ff <= e2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e3_run_ff   <= e2_run_ff;
         e3_frame_ff <= e2_frame_ff;
         e3_red_ff   <= tot_red;
         e3_green_ff <= tot_green;
         e3_blue_ff  <= tot_blue;
      end
   end

   // output register: divide by the kernel total through a reciprocal
   logic [PROD_W-1:0] prod_red;
   logic [PROD_W-1:0] prod_green;
   logic [PROD_W-1:0] prod_blue;
   logic [7:0]        rsp_red_ff;
   logic [7:0]        rsp_green_ff;
   logic [7:0]        rsp_blue_ff;
   logic              rsp_run_ff;
   logic              rsp_frame_ff;

   assign prod_red   = PROD_W'(e3_red_ff)   * PROD_W'(DIV_MULT);
   assign prod_green = PROD_W'(e3_green_ff) * PROD_W'(DIV_MULT);
   assign prod_blue  = PROD_W'(e3_blue_ff)  * PROD_W'(DIV_MULT);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= e3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_red_ff   <= prod_red[DIV_SHIFT +: CH_W];
         rsp_green_ff <= prod_green[DIV_SHIFT +: CH_W];
         rsp_blue_ff  <= prod_blue[DIV_SHIFT +: CH_W];
         rsp_run_ff   <= e3_run_ff;
         rsp_frame_ff <= e3_frame_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_red_out       = rsp_red_ff;
   assign rsp_green_out     = rsp_green_ff;
   assign rsp_blue_out      = rsp_blue_ff;
   assign rsp_last_of_run   = rsp_run_ff;
   assign rsp_last_of_frame = rsp_frame_ff;

   // no input transfer while the right edge is being replayed
   a_no_accept_in_replay: assert property (@(posedge clock) disable iff (reset)
      (extra_cnt_ff != 2'd0) |-> !accept)
      else $error("input transfer during edge replay");

   // a row end from row 3 on always starts a three step replay
   a_replay_start: assert property (@(posedge clock) disable iff (reset)
      (s1_move && s1_row_end_ff && s1_r_ge3_ff) |=> (extra_cnt_ff == 2'd3))
      else $error("edge replay did not start");

   // the frame end flag only travels on the last result of a run
   a_frame_on_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_frame_ff) |-> rsp_run_ff)
      else $error("frame end without run end");

   // a stalled result keeps its flags
   a_hold_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> ($stable(rsp_run_ff) && $stable(rsp_frame_ff)))
      else $error("stalled result changed");

endmodule

[tb/testbench.sv]
// self-checking testbench for the streaming 7x7 gaussian blur with replicated edges
`timescale 1ns / 1ps
module testbench;
   import gb7_pkg::*;

   localparam int LINE_MAX   = 1024;
   localparam int CYCLE_CAP  = 3000000;
   localparam int DRAIN_WAIT = 20;

   // one pixel transfer on the input side
   typedef struct {
      logic       mode;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_in_type;

   // one blurred pixel as it should leave the block
   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_run;
      logic       last_frame;
   } blur_px_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_mode = 1'b0;
   logic [7:0] req_red_in = '0;
   logic [7:0] req_green_in = '0;
   logic [7:0] req_blue_in = '0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_red_out;
   logic [7:0] rsp_green_out;
   logic [7:0] rsp_blue_out;
   logic       rsp_last_of_run;
   logic       rsp_last_of_frame;

   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = REG_IMAGE_WIDTH;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   gaussian_blur_7x7_clamp_edge u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_red_in        (req_red_in),
      .req_green_in      (req_green_in),
      .req_blue_in       (req_blue_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_red_out       (rsp_red_out),
      .rsp_green_out     (rsp_green_out),
      .rsp_blue_out      (rsp_blue_out),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // blur predictor: own copy of the registers, line store, window and counters
   // ---------------------------------------------------------------------------
   logic [IMG_W_REG_W-1:0] width_reg;
   logic [IMG_H_REG_W-1:0] height_reg;
   logic [PIX_W-1:0]       line_mem [0:5][0:LINE_MAX-1];
   logic [PIX_W-1:0]       win [0:TAPS-1][0:TAPS-1];
   int unsigned            col_pos;
   int unsigned            row_pos;

   pixel_in_type pending_px[$];   // items waiting for the driver
   blur_px_type  blurred_q[$];    // expected blurred pixels, oldest first
   bit        failed = 1'b0;
   bit        quiet  = 1'b0;   // no idling on either side in the closing part
   int unsigned cycles = 0;

   function automatic int unsigned eff_width();
      int unsigned w;
      w = width_reg;
      if (w < 4) w = 4;
      if (w > LINE_MAX) w = LINE_MAX;
      return w;
   endfunction

   function automatic int unsigned eff_height();
      int unsigned h;
      h = height_reg;
      if (h < 4) h = 4;
      if (h > 4096) h = 4096;
      return h;
   endfunction

   task automatic shift_in(input logic [PIX_W-1:0] col [0:TAPS-1]);
      for (int k = 0; k < TAPS; k++) begin
         for (int m = 0; m < TAPS - 1; m++) win[k][m] = win[k][m+1];
         win[k][TAPS-1] = col[k];
      end
   endtask

   // weighted sum of the window per channel, divided by the kernel total
   task automatic push_blurred(input logic last_run, input logic last_frame);
      int unsigned sr, sg, sb, wt;
      blur_px_type px;
      sr = 0; sg = 0; sb = 0;
      for (int k = 0; k < TAPS; k++) begin
         for (int m = 0; m < TAPS; m++) begin
            wt = KERNEL[k][m];
            sr += win[k][m][23:16] * wt;
            sg += win[k][m][15:8] * wt;
            sb += win[k][m][7:0] * wt;
         end
      end
      px.red        = 8'(sr / 84);
      px.green      = 8'(sg / 84);
      px.blue       = 8'(sb / 84);
      px.last_run   = last_run;
      px.last_frame = last_frame;
      blurred_q.push_back(px);
   endtask

   task automatic predict_blur(input pixel_in_type it);
      int unsigned      w, h, c, r;
      logic [PIX_W-1:0] pix;
      logic [PIX_W-1:0] col [0:TAPS-1];
      bit               row_end, frame_end;
      w = eff_width();
      h = eff_height();
      c = (col_pos >= LINE_MAX) ? LINE_MAX - 1 : col_pos;
      r = row_pos;
      pix = {it.red, it.green, it.blue};
      // a drain item repeats the pixel above, except on the top row
      if (it.mode && r != 0) pix = line_mem[5][c];
      if (r == 0) begin
         for (int k = 0; k < TAPS; k++) col[k] = pix;
         for (int k = 0; k < 6; k++) line_mem[k][c] = pix;
      end else begin
         for (int k = 0; k < 6; k++) col[k] = line_mem[k][c];
         col[6] = pix;
         for (int k = 0; k < 5; k++) line_mem[k][c] = col[k+1];
         line_mem[5][c] = pix;
      end
      // left edge replicated across the whole window
      if (c == 0) begin
         for (int i = 0; i < TAPS; i++) shift_in(col);
      end else begin
         shift_in(col);
      end
      row_end   = (c >= w - 1);
      frame_end = row_end && (r >= h + 2);
      if (r >= 3 && c >= 3) push_blurred(!row_end, 1'b0);
      // right edge: replay the last column three times
      if (r >= 3 && row_end) begin
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < TAPS; k++) col[k] = win[k][TAPS-1];
            shift_in(col);
            push_blurred(i == 2, i == 2 && frame_end);
         end
      end
      if (row_end) begin
         col_pos = 0;
         row_pos = (r >= h + 2) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   // ---------------------------------------------------------------------------
   // driver: one nonblocking update per signal per edge, bursts of idling
   // ---------------------------------------------------------------------------
   int unsigned req_gap = 0;

   always @(posedge clock) begin
      pixel_in_type nxt;
      bit           send;
      if (!reset && req_valid && !req_stall) begin
         nxt.mode = req_mode; nxt.red = req_red_in;
         nxt.green = req_green_in; nxt.blue = req_blue_in;
         predict_blur(nxt);
      end
      if (reset || (req_valid && req_stall)) begin
         // hold a stalled transfer unchanged
      end else begin
         send = 1'b0;
         if (req_gap > 0) req_gap--;
         else if (!quiet && $urandom_range(0, 15) == 0) req_gap = $urandom_range(1, 19);
         else if (pending_px.size() > 0) send = 1'b1;
         if (send) begin
            nxt = pending_px.pop_front();
            req_mode <= nxt.mode; req_red_in <= nxt.red;
            req_green_in <= nxt.green; req_blue_in <= nxt.blue;
         end
         req_valid <= send;
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: stall bursts and field-by-field compare against the oldest expectation
   // ---------------------------------------------------------------------------
   int unsigned rsp_gap = 0;

   always @(posedge clock) begin
      blur_px_type exp_px;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (blurred_q.size() == 0) begin
            $error("blurred pixel transfer with nothing expected");
            failed = 1'b1;
         end else begin
            exp_px = blurred_q.pop_front();
            if (rsp_red_out !== exp_px.red) begin
               $error("red_out expected %0d actual %0d", exp_px.red, rsp_red_out);
               failed = 1'b1;
            end
            if (rsp_green_out !== exp_px.green) begin
               $error("green_out expected %0d actual %0d", exp_px.green, rsp_green_out);
               failed = 1'b1;
            end
            if (rsp_blue_out !== exp_px.blue) begin
               $error("blue_out expected %0d actual %0d", exp_px.blue, rsp_blue_out);
               failed = 1'b1;
            end
            if (rsp_last_of_run !== exp_px.last_run) begin
               $error("last_of_run expected %0d actual %0d", exp_px.last_run,
                      rsp_last_of_run);
               failed = 1'b1;
            end
            if (rsp_last_of_frame !== exp_px.last_frame) begin
               $error("last_of_frame expected %0d actual %0d", exp_px.last_frame,
                      rsp_last_of_frame);
               failed = 1'b1;
            end
         end
      end
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_stall <= (rsp_gap != 0);
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
         rsp_gap = $urandom_range(1, 19);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DAT_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_IMAGE_WIDTH) width_reg = IMG_W_REG_W'(value);
      else height_reg = IMG_H_REG_W'(value);
   endtask

   // wait until every item is sent and every blurred pixel has come back
   task automatic settle();
      do @(posedge clock);
      while (pending_px.size() != 0 || req_valid || blurred_q.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic [7:0] chan_value(input int unsigned sel);
      case (sel)
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // one whole frame: image rows then three drain rows; noisy frames mix modes
   task automatic queue_frame(input bit noisy, input int unsigned sel_hi);
      int unsigned  w, h;
      pixel_in_type it;
      w = eff_width();
      h = eff_height();
      for (int unsigned r = 0; r < h + 3; r++) begin
         for (int unsigned c = 0; c < w; c++) begin
            it.mode  = noisy ? 1'($urandom_range(0, 1)) : (r >= h);
            it.red   = chan_value($urandom_range(0, sel_hi));
            it.green = chan_value($urandom_range(0, sel_hi));
            it.blue  = chan_value($urandom_range(0, sel_hi));
            pending_px.push_back(it);
         end
      end
   endtask

   initial begin
      int unsigned sent;
      width_reg  = 11'd1024;
      height_reg = 13'd1024;
      col_pos = 0;
      row_pos = 0;
      sent = 0;
      for (int k = 0; k < 6; k++)
         for (int c = 0; c < LINE_MAX; c++) line_mem[k][c] = '0;
      for (int k = 0; k < TAPS; k++)
         for (int m = 0; m < TAPS; m++) win[k][m] = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // smallest frame via saturation from zero, channels at 0 and 255 only
      csr_write(REG_IMAGE_WIDTH, 0);
      csr_write(REG_IMAGE_HEIGHT, 0);
      sent += eff_width() * (eff_height() + 3);
      queue_frame(1'b0, 1);
      settle();
      // mixed modes: drain items may land on the top row and real pixels in the drain rows
      csr_write(REG_IMAGE_WIDTH, 5);
      csr_write(REG_IMAGE_HEIGHT, 4);
      sent += eff_width() * (eff_height() + 3);
      queue_frame(1'b1, 2);
      settle();

      // random small frames, mostly well formed, some with mixed modes
      while (sent < 500) begin
         if (sent > 400) quiet = 1'b1;
         csr_write(REG_IMAGE_WIDTH, $urandom_range(0, 9));
         csr_write(REG_IMAGE_HEIGHT, $urandom_range(0, 8));
         sent += eff_width() * (eff_height() + 3);
         queue_frame($urandom_range(0, 4) == 0, 8);
         settle();
      end

      if (!failed) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/gb7_pkg.sv
rtl/gb7_ram.sv
rtl/gb7_cell.sv
rtl/gaussian_blur_7x7_clamp_edge.sv
tb/testbench.sv
